FILE: rtl/core/isqrt_pkg.sv
// Shared types and constants for the integer square root block.
`default_nettype none

package isqrt_pkg;

  localparam int unsigned RadicandW = 31;
  localparam int unsigned RootW     = 16;
  localparam int unsigned StepCnt   = RootW;
  localparam int unsigned StepCntW  = $clog2(StepCnt);

  localparam logic [RadicandW-1:0] FirstBit = {1'b1, {(RadicandW-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } isqrt_state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic publish;
  } isqrt_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/isqrt_dp.sv
// Datapath of the integer square root block: remainder, root accumulator, result register.
`default_nettype none

module isqrt_dp import isqrt_pkg::*; (
  input  wire logic                 clk_i,
  input  wire isqrt_cmd_t           cmd_i,
  input  wire logic [RadicandW-1:0] radicand_i,
  output logic      [RootW-1:0]     root_o
);

  logic [RadicandW-1:0] rem_q, rem_d;
  logic [RadicandW-1:0] acc_q, acc_d;
  logic [RadicandW-1:0] bit_q, bit_d;
  logic [RootW-1:0]     root_q, root_d;
  logic [RadicandW:0]   trial;
  logic                 fits;

  assign trial = {1'b0, acc_q} + {1'b0, bit_q};
  assign fits  = ({1'b0, rem_q} >= trial);

  always_comb begin
    rem_d  = rem_q;
    acc_d  = acc_q;
    bit_d  = bit_q;
    root_d = root_q;
    if (cmd_i.load) begin
      rem_d = radicand_i;
      acc_d = '0;
      bit_d = FirstBit;
    end else if (cmd_i.step) begin
      if (fits) begin
        rem_d = rem_q - trial[RadicandW-1:0];
        acc_d = (acc_q >> 1) + bit_q;
      end else begin
        acc_d = acc_q >> 1;
      end
      bit_d = bit_q >> 2;
    end
    if (cmd_i.publish) begin
      root_d = acc_q[RootW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    acc_q  <= acc_d;
    bit_q  <= bit_d;
    root_q <= root_d;
  end

  assign root_o = root_q;

endmodule

`default_nettype wire

FILE: rtl/core/isqrt_ctrl.sv
// Controller of the integer square root block: handshakes and step sequencing.
`default_nettype none

module isqrt_ctrl import isqrt_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output isqrt_cmd_t cmd_o
);

  isqrt_state_e        state_q, state_d;
  logic [StepCntW-1:0] cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;
  logic                slot_free;
  logic                in_take;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_take = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    out_valid_d   = out_valid_q;
    cmd_o.load    = 1'b0;
    cmd_o.step    = 1'b0;
    cmd_o.publish = 1'b0;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == StepCntW'(StepCnt - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd_o.publish = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: rtl/core/integer_square_root.sv
// Top level of the integer square root block: floor root of a 31-bit radicand.
// One root bit per cycle in the RUN state; the result is then published to root_o.
// Per request: load, 16 subtract-compare steps, publish; the next waits until publish.
// A waiting result sits in the output register while the next request is taken.
// Reset: asynchronous, active low; clears the controller and the result valid flag.
`default_nettype none

module integer_square_root import isqrt_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [RadicandW-1:0] radicand_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic      [RootW-1:0]     root_o
);

  isqrt_cmd_t cmd;

  isqrt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  isqrt_dp u_dp (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .radicand_i (radicand_i),
    .root_o     (root_o)
  );

endmodule

`default_nettype wire
